[hdl/hkca_pkg.sv]
`default_nettype none
package hkca_pkg;

	typedef logic [1:0] status_t;

	// result status codes
	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_MISS = 2'd1;
	localparam status_t ST_FULL = 2'd2;

	// item function codes
	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// hash mix multipliers
	localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
	localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;

endpackage
`default_nettype wire

[hdl/hkca_ram.sv]
`default_nettype none
module hkca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[hdl/hkca_mixer.sv]
`default_nettype none
// shared multiply-xorshift unit, one step of the hash mix per cycle
module hkca_mixer (
	input  wire         step,
	input  wire  [31:0] operand,
	output logic [31:0] result
);

	logic [31:0] mul;
	logic [31:0] p;

	always_comb begin
		mul    = step ? hkca_pkg::MIX_MUL_B : hkca_pkg::MIX_MUL_A;
		// only the low word of the product is kept
		p      = operand * mul;
		// first step shifts by 15, second by 16
		result = step ? (p ^ (p >> 16)) : (p ^ (p >> 15));
	end

endmodule
`default_nettype wire

[hdl/hashed_key_count_accumulator_unit.sv]
`default_nettype none
// hashed key count accumulator
// open-addressing table with linear probing, 32-bit keys to 64-bit counters
//
// input channel: an item (func, key, amount) is taken at a rising edge with
// start high and busy low. func add sums amount into the key's counter
// (inserting the key if absent), func lookup reads the counter.
// result channel: done is high for exactly one cycle with status and
// count_value; the receiver cannot stall, so nothing waits on it.
//
// sequence: an accepted item passes through two multiply steps of the
// shared hash unit, then a read and a check per slot probed through the
// registered-read slot memory, until busy drops again. done shows in the
// cycle busy drops, and a new item may be accepted in that same cycle.
//
// reset: the slot memory is swept one entry a cycle to clear the valid
// marks, with busy held high; the occupancy count is zero.
// a new key that would bring occupancy to 3/4 of CAPACITY is refused.
module hashed_key_count_accumulator_unit #(
	parameter int CAPACITY = 1024
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire                   func,
	input  wire  [31:0]           key,
	input  wire  [63:0]           amount,
	output logic                  done,
	output hkca_pkg::status_t     status,
	output logic [63:0]           count_value
);

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int LIMIT  = CAPACITY * 3 / 4;

	// sequencer states
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MUL1  = 3'd2;
	localparam logic [2:0] S_MUL2  = 3'd3;
	localparam logic [2:0] S_PROBE = 3'd4;
	localparam logic [2:0] S_CHECK = 3'd5;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [CNT_W-1:0]  occ_q;
	logic              done_q;

	// item and walk registers
	logic              func_q;
	logic [31:0]       key_q;
	logic [63:0]       amount_q;
	logic [31:0]       v_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] n_q;
	hkca_pkg::status_t status_q;
	logic [63:0]       count_q;

	// slot memory ports
	logic              kv_we;
	logic [ADDR_W-1:0] kv_waddr;
	logic [32:0]       kv_wdata;
	logic [32:0]       kv_rd;
	logic              cnt_we;
	logic [63:0]       cnt_wdata;
	logic [63:0]       cnt_rd;

	// probe decode
	logic              is_lookup;
	logic              empty;
	logic              hit;
	logic              at_limit;
	logic              last_probe;
	logic              resolved;
	logic [63:0]       sum;
	logic [31:0]       mix_out;

	hkca_mixer u_mixer (
		.step    (state_q == S_MUL2),
		.operand (v_q),
		.result  (mix_out)
	);

	// valid mark and key, one word per slot
	hkca_ram #(
		.WIDTH (33),
		.DEPTH (CAPACITY)
	) u_key_ram (
		.clk   (clk),
		.we    (kv_we),
		.waddr (kv_waddr),
		.wdata (kv_wdata),
		.raddr (idx_q),
		.rdata (kv_rd)
	);

	// counters, read at each probed slot, used only on a key match
	hkca_ram #(
		.WIDTH (64),
		.DEPTH (CAPACITY)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (idx_q),
		.wdata (cnt_wdata),
		.raddr (idx_q),
		.rdata (cnt_rd)
	);

	always_comb begin
		is_lookup  = (func_q == hkca_pkg::FUNC_LOOKUP);
		empty      = !kv_rd[32];
		hit        = kv_rd[32] && (kv_rd[31:0] == key_q);
		// occ + 1 >= CAPACITY * 3 / 4, integer division
		at_limit   = occ_q >= CNT_W'(LIMIT - 1);
		last_probe = (n_q == ADDR_W'(CAPACITY - 1));
		resolved   = empty || hit || last_probe;
		sum        = cnt_rd + amount_q;

		// sweep writes zero, insert writes the key with its valid mark
		kv_we    = (state_q == S_CLEAR) ||
			((state_q == S_CHECK) && empty && !is_lookup && !at_limit);
		kv_waddr = (state_q == S_CLEAR) ? clr_q : idx_q;
		kv_wdata = (state_q == S_CLEAR) ? 33'd0 : {1'b1, key_q};

		cnt_we    = (state_q == S_CHECK) && !is_lookup &&
			((empty && !at_limit) || hit);
		cnt_wdata = hit ? sum : amount_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_PROBE;
				S_PROBE: state_q <= S_CHECK;
				S_CHECK: begin
					if (resolved) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						if (empty && !is_lookup && !at_limit) begin
							occ_q <= occ_q + 1'b1;
						end
					end else begin
						state_q <= S_PROBE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload, hash and probe position
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					func_q   <= func;
					key_q    <= key;
					amount_q <= amount;
					v_q      <= key ^ (key >> 16);
				end
			end
			S_MUL1: v_q <= mix_out;
			S_MUL2: begin
				idx_q <= mix_out[ADDR_W-1:0];
				n_q   <= '0;
			end
			S_CHECK: begin
				idx_q <= idx_q + 1'b1;
				n_q   <= n_q + 1'b1;
				if (empty) begin
					if (is_lookup) begin
						status_q <= hkca_pkg::ST_MISS;
						count_q  <= '0;
					end else if (at_limit) begin
						status_q <= hkca_pkg::ST_FULL;
						count_q  <= '0;
					end else begin
						status_q <= hkca_pkg::ST_OK;
						count_q  <= amount_q;
					end
				end else if (hit) begin
					status_q <= hkca_pkg::ST_OK;
					count_q  <= is_lookup ? cnt_rd : sum;
				end else begin
					// another key's slot; on the last probe every slot was walked without a match or a hole
					status_q <= is_lookup ? hkca_pkg::ST_MISS : hkca_pkg::ST_FULL;
					count_q  <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign count_value = count_q;

endmodule
`default_nettype wire

[hdl/hkca_checker.sv]
`default_nettype none
module hkca_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                start,
	input wire                busy,
	input wire                done,
	input hkca_pkg::status_t  status,
	input wire [63:0]         count_value
);

	// an accepted item raises busy at the clock edge that takes it
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// a result lands as the block becomes free again
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// no two results back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// a miss or refusal carries a zero counter
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != hkca_pkg::ST_OK) |-> (count_value == 64'd0))
		else $error("nonzero counter with failing status");

endmodule

bind hashed_key_count_accumulator_unit hkca_checker u_hkca_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.count_value (count_value)
);
`default_nettype wire
